// File: design/cctw_pkg.sv
// Package for the CPU completion timing wheel.
// Holds the action codes and the fixed field widths; depends on nothing.
package cctw_pkg;

   // widths of the word fields
   localparam int ACTION_W = 1;
   localparam int BURST_W  = 8;
   localparam int CPU_W    = 3;
   localparam int DELAY_W  = 8;
   localparam int MASK_W   = 8;
   localparam int SLOT_W   = 8;

   // action codes
   localparam logic [ACTION_W-1:0] ACTION_INSERT = 1'b0;
   localparam logic [ACTION_W-1:0] ACTION_TICK   = 1'b1;

   // delay cap after reset
   localparam logic [DELAY_W-1:0] DELAY_CAP_RESET = 8'd255;

endpackage

// File: design/cpu_completion_timing_wheel.sv
// Top level of the CPU completion timing wheel.
// Depends on cctw_pkg for action codes and field widths.
//
// The block keeps a wheel of min(delay cap + 1, WHEEL_SLOTS) slots, a current-slot
// pointer and a mask of free CPUs. An insert word puts a free CPU into the slot
// burst_ticks ahead of the pointer and marks it busy; a busy CPU (or an index at or
// above CPU_COUNT) is reported as a conflict, a burst above the last slot is reported
// as too long, and either leaves the state untouched. A tick word frees every CPU in
// the current slot, reports them in freed_cpus, and advances the pointer with wrap.
// Every word gives exactly one result word. Since a CPU sits in at most one slot at a
// time, the wheel is held as one slot tag per CPU next to the free mask: the slot
// contents are the busy CPUs whose tag equals the slot number. The free-mask lookup,
// the slot sum with its single wrap correction and the per-CPU tag compare all settle
// between the request port and the result register, so a new word is taken every
// cycle as long as each result is taken as it appears; a result that waits holds off
// the request port until it is taken.
// Writing the delay cap resizes the wheel, frees every CPU and returns the pointer to
// slot 0 in the same cycle; write it only while no word is in flight.
module cpu_completion_timing_wheel #(
   parameter int WHEEL_SLOTS = 256,
   parameter int CPU_COUNT   = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [cctw_pkg::ACTION_W-1:0]     req_action,
   input  logic [cctw_pkg::BURST_W-1:0]      req_burst_ticks,
   input  logic [cctw_pkg::CPU_W-1:0]        req_cpu_index,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_accepted,
   output logic                              rsp_cpu_conflict,
   output logic                              rsp_burst_too_long,
   output logic [cctw_pkg::SLOT_W-1:0]       rsp_slot_used,
   output logic [cctw_pkg::MASK_W-1:0]       rsp_freed_cpus,
   output logic [cctw_pkg::MASK_W-1:0]       rsp_free_cpus_after,
   // delay cap register
   input  logic                              csr_wr_en,
   input  logic [cctw_pkg::DELAY_W-1:0]      csr_wr_data
);

   // pointer / tag width
   localparam int PW  = (WHEEL_SLOTS > 1) ? $clog2(WHEEL_SLOTS) : 1;
   // width that holds the wheel size itself and the delay cap + 1
   localparam int SZL = $clog2(WHEEL_SLOTS + 1);
   localparam int SZW = (SZL > cctw_pkg::DELAY_W + 1) ? SZL : cctw_pkg::DELAY_W + 1;
   // widest slot value, then the arithmetic width for pointer + burst
   localparam int SLW = (PW > cctw_pkg::SLOT_W) ? PW : cctw_pkg::SLOT_W;
   localparam int CW  = (SLW + 1 > SZW) ? SLW + 1 : SZW;
   // mask width padded to at least the port width
   localparam int MW  = (CPU_COUNT > cctw_pkg::MASK_W) ? CPU_COUNT : cctw_pkg::MASK_W;

   logic                 rsp_valid_ff;
   logic                 accepted_ff;
   logic                 conflict_ff;
   logic                 too_long_ff;
   logic [cctw_pkg::SLOT_W-1:0] slot_ff;
   logic [cctw_pkg::MASK_W-1:0] freed_ff;
   logic [cctw_pkg::MASK_W-1:0] free_after_ff;

   logic [SZW-1:0]       size_ff;
   logic [SZW-1:0]       size_in;
   logic [PW-1:0]        ptr_ff;
   logic [PW-1:0]        ptr_in;
   logic [CPU_COUNT-1:0] free_ff;
   logic [CPU_COUNT-1:0] free_in;
   logic [PW-1:0]        tag_ff [CPU_COUNT];
   logic [PW-1:0]        tag_in [CPU_COUNT];

   logic                 take;
   logic                 is_tick;
   logic [CPU_COUNT-1:0] cpu_sel;
   logic [CPU_COUNT-1:0] expire;
   logic                 busy;
   logic                 too_long;
   logic                 place;
   logic [CW-1:0]        size_c;
   logic [CW-1:0]        ptr_c;
   logic [CW-1:0]        burst_c;
   logic [CW-1:0]        sum_c;
   logic [CW-1:0]        target_c;
   logic [CW-1:0]        ptr_next_c;
   logic [CW-1:0]        slot_c;
   logic [CPU_COUNT-1:0] freed_mask;
   logic [MW-1:0]        freed_wide;
   logic [MW-1:0]        free_wide;
   logic [SZW-1:0]       delay_plus_one;

   // the result register parts the two sides: take a word whenever the slot empties
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign take      = req_valid && req_ready;
   assign is_tick   = (req_action == cctw_pkg::ACTION_TICK);

   // size after a delay cap write, capped at the physical wheel
   assign delay_plus_one = SZW'(csr_wr_data) + SZW'(1);
   assign size_in = (delay_plus_one > SZW'(WHEEL_SLOTS)) ? SZW'(WHEEL_SLOTS) : delay_plus_one;

   assign size_c  = CW'(size_ff);
   assign ptr_c   = CW'(ptr_ff);
   assign burst_c = CW'(req_burst_ticks);

   // target slot: for a burst that fits, pointer and burst are both below the size, so one wrap at most
   assign sum_c    = ptr_c + burst_c;
   assign target_c = (sum_c >= size_c) ? sum_c - size_c : sum_c;
   assign too_long = (burst_c >= size_c);

   // advance the pointer with wrap at the wheel size
   assign ptr_next_c = (ptr_c + CW'(1) >= size_c) ? '0 : ptr_c + CW'(1);

   // decode the CPU; an index past the last CPU matches nothing and reads as busy
   always_comb begin
      for (int c = 0; c < CPU_COUNT; c++) begin
         cpu_sel[c] = (int'(req_cpu_index) == c);
         expire[c]  = !free_ff[c] && (tag_ff[c] == ptr_ff);
      end
   end

   assign busy  = !(|(cpu_sel & free_ff));
   assign place = !is_tick && !too_long && !busy;

   // next mask, tags and pointer for the word at the port
   always_comb begin
      free_in    = free_ff;
      ptr_in     = ptr_ff;
      freed_mask = '0;
      for (int c = 0; c < CPU_COUNT; c++) begin
         tag_in[c] = tag_ff[c];
      end
      if (is_tick) begin
         freed_mask = expire;
         free_in    = free_ff | expire;
         ptr_in     = ptr_next_c[PW-1:0];
      end else if (place) begin
         free_in = free_ff & ~cpu_sel;
         for (int c = 0; c < CPU_COUNT; c++) begin
            if (cpu_sel[c]) begin
               tag_in[c] = target_c[PW-1:0];
            end
         end
      end
   end

   // tick reports the expired slot; a too-long insert reports slot 0
   assign slot_c = is_tick ? ptr_c : (too_long ? '0 : target_c);

   assign freed_wide = MW'(freed_mask);
   assign free_wide  = MW'(free_in);

   // wheel state
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= (SZW'(WHEEL_SLOTS) < SZW'(cctw_pkg::DELAY_CAP_RESET) + SZW'(1))
                    ? SZW'(WHEEL_SLOTS) : SZW'(cctw_pkg::DELAY_CAP_RESET) + SZW'(1);
         ptr_ff  <= '0;
         free_ff <= '1;
      end else if (csr_wr_en) begin
         // resize: drop every scheduled CPU and restart at slot 0
         size_ff <= size_in;
         ptr_ff  <= '0;
         free_ff <= '1;
      end else if (take) begin
         ptr_ff  <= ptr_in;
         free_ff <= free_in;
      end
   end

   // slot tags are only meaningful while the CPU is busy
   always_ff @(posedge clock) begin
      if (take) begin
         for (int c = 0; c < CPU_COUNT; c++) begin
            tag_ff[c] <= tag_in[c];
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         accepted_ff   <= place;
         conflict_ff   <= !is_tick && busy;
         too_long_ff   <= !is_tick && too_long;
         slot_ff       <= slot_c[cctw_pkg::SLOT_W-1:0];
         freed_ff      <= freed_wide[cctw_pkg::MASK_W-1:0];
         free_after_ff <= free_wide[cctw_pkg::MASK_W-1:0];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_accepted        = accepted_ff;
   assign rsp_cpu_conflict    = conflict_ff;
   assign rsp_burst_too_long  = too_long_ff;
   assign rsp_slot_used       = slot_ff;
   assign rsp_freed_cpus      = freed_ff;
   assign rsp_free_cpus_after = free_after_ff;

endmodule

// File: dv/cpu_completion_timing_wheel_tb.sv
// Self-checking testbench for cpu_completion_timing_wheel.
// Depends on cctw_pkg and the block itself; drives random bursts, stalls and
// delay cap changes and checks every response word against a local wheel model.
module cpu_completion_timing_wheel_tb;

   localparam int WHEEL_SLOTS  = 256;
   localparam int CPU_COUNT    = 8;
   localparam int PHASE_WORDS  = 94;

   typedef struct packed {
      logic [cctw_pkg::ACTION_W-1:0] action;
      logic [cctw_pkg::BURST_W-1:0]  burst;
      logic [cctw_pkg::CPU_W-1:0]    cpu;
   } sched_word_type;

   typedef struct packed {
      logic                          accepted;
      logic                          conflict;
      logic                          too_long;
      logic [cctw_pkg::SLOT_W-1:0]   slot;
      logic [cctw_pkg::MASK_W-1:0]   freed;
      logic [cctw_pkg::MASK_W-1:0]   free_after;
   } wheel_result_type;

   // block ports; every input holds a known value from time zero
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [cctw_pkg::ACTION_W-1:0] req_action = cctw_pkg::ACTION_INSERT;
   logic [cctw_pkg::BURST_W-1:0]  req_burst_ticks = '0;
   logic [cctw_pkg::CPU_W-1:0]    req_cpu_index = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic                          rsp_accepted;
   logic                          rsp_cpu_conflict;
   logic                          rsp_burst_too_long;
   logic [cctw_pkg::SLOT_W-1:0]   rsp_slot_used;
   logic [cctw_pkg::MASK_W-1:0]   rsp_freed_cpus;
   logic [cctw_pkg::MASK_W-1:0]   rsp_free_cpus_after;
   logic                          csr_wr_en = 1'b0;
   logic [cctw_pkg::DELAY_W-1:0]  csr_wr_data = '0;

   // shadow of the wheel: one CPU mask per slot, the pointer, the free mask
   logic [cctw_pkg::MASK_W-1:0]   shadow_slot [WHEEL_SLOTS];
   int                            shadow_ptr;
   logic [cctw_pkg::MASK_W-1:0]   free_mask;
   logic [cctw_pkg::DELAY_W-1:0]  delay_limit;

   sched_word_type      word_backlog[$];     // words not yet offered
   wheel_result_type    due_results[$];      // predictions awaiting their response
   sched_word_type      held_word;           // word on the request port right now
   int                  burst_left;
   int                  gap_left;
   int                  stall_mode;
   int                  cycle_count;
   int                  mismatch_count;

   cpu_completion_timing_wheel #(
      .WHEEL_SLOTS(WHEEL_SLOTS),
      .CPU_COUNT  (CPU_COUNT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_action         (req_action),
      .req_burst_ticks    (req_burst_ticks),
      .req_cpu_index      (req_cpu_index),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_accepted       (rsp_accepted),
      .rsp_cpu_conflict   (rsp_cpu_conflict),
      .rsp_burst_too_long (rsp_burst_too_long),
      .rsp_slot_used      (rsp_slot_used),
      .rsp_freed_cpus     (rsp_freed_cpus),
      .rsp_free_cpus_after(rsp_free_cpus_after),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Empty every slot, park the pointer at slot 0 and free all CPUs, as the
   // block does on reset and on any delay cap write.
   function automatic void clear_shadow();
      for (int i = 0; i < WHEEL_SLOTS; i++) begin
         shadow_slot[i] = '0;
      end
      shadow_ptr = 0;
      free_mask  = '1;
   endfunction

   // Work out the response to one word and advance the shadow wheel.
   function automatic wheel_result_type wheel_outcome(sched_word_type w);
      wheel_result_type r;
      int            size;
      int            target;
      logic          busy;
      r    = '0;
      size = int'(delay_limit) + 1;
      if (size > WHEEL_SLOTS) begin
         size = WHEEL_SLOTS;
      end
      if (shadow_ptr >= size) begin
         shadow_ptr = 0;
      end
      if (w.action == cctw_pkg::ACTION_TICK) begin
         // expire the current slot: its CPUs become free
         r.freed                 = shadow_slot[shadow_ptr];
         free_mask               = free_mask | r.freed;
         shadow_slot[shadow_ptr] = '0;
         r.slot                  = shadow_ptr[cctw_pkg::SLOT_W-1:0];
         shadow_ptr              = (shadow_ptr + 1) % size;
      end else begin
         // an index past the CPU count names a CPU that is never free
         busy = 1'b1;
         if (int'(w.cpu) < CPU_COUNT) begin
            busy = ~free_mask[w.cpu];
         end
         r.too_long = (int'(w.burst) > size - 1);
         r.conflict = busy;
         if (!r.too_long) begin
            target = (shadow_ptr + int'(w.burst)) % size;
            r.slot = target[cctw_pkg::SLOT_W-1:0];
            if (!busy) begin
               shadow_slot[target][w.cpu] = 1'b1;
               free_mask[w.cpu]           = 1'b0;
               r.accepted                 = 1'b1;
            end
         end
      end
      r.free_after = free_mask;
      return r;
   endfunction

   function automatic void flag_error(string msg);
      if (mismatch_count < 10) begin
         $display("ERROR at cycle %0d: %s", cycle_count, msg);
      end
      mismatch_count++;
   endfunction

   function automatic void check_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
         flag_error($sformatf("%s expected 0x%0h got 0x%0h", name, exp_val, act_val));
      end
   endfunction

   // Driver: offer words in bursts of random length with random gaps between
   // them. Hold valid and the payload until the word is taken.
   always @(posedge clock) begin
      if (!reset) begin
         cycle_count++;
         if (req_valid && req_ready) begin
            due_results.push_back(wheel_outcome(held_word));
         end
         if (!req_valid || req_ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (word_backlog.size() > 0) begin
               held_word       = word_backlog.pop_front();
               req_valid       <= 1'b1;
               req_action      <= held_word.action;
               req_burst_ticks <= held_word.burst;
               req_cpu_index   <= held_word.cpu;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // end of burst: half the time go straight on, else pause
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each taken response with the oldest prediction, and
   // pick the next ready value from a stall mode that is redrawn at random.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (due_results.size() == 0) begin
               flag_error("response word with nothing predicted");
            end else begin
               wheel_result_type want;
               want = due_results.pop_front();
               check_field("accepted", int'(want.accepted), int'(rsp_accepted));
               check_field("cpu_conflict", int'(want.conflict), int'(rsp_cpu_conflict));
               check_field("burst_too_long", int'(want.too_long),
                           int'(rsp_burst_too_long));
               check_field("slot_used", int'(want.slot), int'(rsp_slot_used));
               check_field("freed_cpus", int'(want.freed), int'(rsp_freed_cpus));
               check_field("free_cpus_after", int'(want.free_after),
                           int'(rsp_free_cpus_after));
            end
         end
         if (cycle_count % 50 == 0) begin
            stall_mode = $urandom_range(0, 3);
         end
         case (stall_mode)
            0: begin
               rsp_ready <= 1'b1;
            end
            1: begin
               rsp_ready <= ($urandom_range(0, 3) != 0);
            end
            2: begin
               rsp_ready <= (cycle_count % 4 != 3);
            end
            default: begin
               rsp_ready <= ($urandom_range(0, 3) == 0);
            end
         endcase
      end
   end

   function automatic void queue_word(logic [cctw_pkg::ACTION_W-1:0] action, int burst,
                                      int cpu);
      sched_word_type w;
      w.action = action;
      w.burst  = burst[cctw_pkg::BURST_W-1:0];
      w.cpu    = cpu[cctw_pkg::CPU_W-1:0];
      word_backlog.push_back(w);
   endfunction

   // Mostly short bursts so CPUs cycle through the wheel; some reach the
   // wheel's edge and some overshoot it. Ticks carry random junk fields.
   function automatic void queue_random(int count);
      int lim;
      int pick;
      lim = (int'(delay_limit) < 12) ? int'(delay_limit) : 12;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            queue_word(cctw_pkg::ACTION_TICK, $urandom_range(0, 255), $urandom_range(0, 7));
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               queue_word(cctw_pkg::ACTION_INSERT, $urandom_range(0, lim),
                          $urandom_range(0, 7));
            end else if (pick < 85) begin
               queue_word(cctw_pkg::ACTION_INSERT, $urandom_range(0, int'(delay_limit)),
                          $urandom_range(0, 7));
            end else begin
               queue_word(cctw_pkg::ACTION_INSERT, $urandom_range(0, 255),
                          $urandom_range(0, 7));
            end
         end
      end
   endfunction

   // Block until every word went out and every response came back, then
   // let the pipe settle.
   task automatic wait_drained();
      while (word_backlog.size() != 0 || req_valid || due_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (3) @(posedge clock);
   endtask

   // Write the delay cap while idle; the block clears the wheel on the write.
   task automatic write_delay_cap(logic [cctw_pkg::DELAY_W-1:0] value);
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      delay_limit = value;
      clear_shadow();
      @(negedge clock);
   endtask

   initial begin
      logic [cctw_pkg::DELAY_W-1:0] phase_delay [8];
      mismatch_count = 0;
      cycle_count    = 0;
      burst_left     = 0;
      gap_left       = 0;
      stall_mode     = 0;
      delay_limit    = cctw_pkg::DELAY_CAP_RESET;
      clear_shadow();
      phase_delay = '{8'd255, 8'd1, 8'd7, 8'd31, 8'd0, 8'd254, 8'd0, 8'd2};
      phase_delay[4] = 8'($urandom_range(2, 253));
      phase_delay[6] = 8'($urandom_range(8, 200));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset wheel of 256 slots: empty tick, placement at both ends of the
      // burst range, a busy CPU, then ticks that free the CPUs in the slots they pass.
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_INSERT, 0, 0);
      queue_word(cctw_pkg::ACTION_INSERT, 255, 7);
      queue_word(cctw_pkg::ACTION_INSERT, 5, 0);
      queue_word(cctw_pkg::ACTION_TICK, 255, 7);
      queue_word(cctw_pkg::ACTION_INSERT, 1, 1);
      queue_word(cctw_pkg::ACTION_INSERT, 1, 2);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      wait_drained();

      // One-slot wheel: only burst 0 fits; a busy CPU with a long burst
      // raises both flags.
      write_delay_cap(8'd0);
      queue_word(cctw_pkg::ACTION_INSERT, 0, 1);
      queue_word(cctw_pkg::ACTION_INSERT, 1, 2);
      queue_word(cctw_pkg::ACTION_INSERT, 255, 1);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);

      // Four-slot wheel: last slot, one past it, and pointer wrap.
      write_delay_cap(8'd3);
      queue_word(cctw_pkg::ACTION_INSERT, 3, 3);
      queue_word(cctw_pkg::ACTION_INSERT, 4, 4);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_INSERT, 2, 5);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);
      queue_word(cctw_pkg::ACTION_TICK, 0, 0);

      // Random phases, each with a fresh delay cap, extremes included.
      for (int p = 0; p < 8; p++) begin
         write_delay_cap(phase_delay[p]);
         queue_random(PHASE_WORDS);
      end

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("cpu_completion_timing_wheel_tb OK");
      end else begin
         $display("cpu_completion_timing_wheel_tb NOT OK");
      end
      $finish;
   end

   // Abort a hung run; a correct run takes a small fraction of this.
   initial begin
      #3000000;
      $display("cpu_completion_timing_wheel_tb NOT OK");
      $finish;
   end

endmodule
